// ===== rtl/core/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
// No dependencies; imported by every module of the block.
package mbp_pkg;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned MAX_CODE_BITS = 32;
  // Longest code actually taken; longer lengths saturate to it.
  localparam int unsigned CODE_LIMIT    =
    (MAX_CODE_BITS < VALUE_BITS) ? MAX_CODE_BITS : VALUE_BITS;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned MAX_BYTES     = 4;
  localparam int unsigned CNT_W         = 3;
  localparam int unsigned IDX_W         = 2;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = 1;
  localparam int unsigned QCNT_W        = 2;

  typedef enum logic [1:0] {
    OP_WRITE       = 2'd0,
    OP_ALIGN_ONES  = 2'd1,
    OP_FLUSH_ZEROS = 2'd2,
    OP_TRAIL_ALIGN = 2'd3
  } op_e;

  // Bytes produced by one input item; bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_BITS-1:0] bytes;
    logic [CNT_W-1:0]                    cnt;
  } packet_t;

endpackage

// ===== rtl/core/mbp_front.sv =====
// Front end: holds the pending bits and turns each accepted word into a
// packet of 0..4 finished bytes. Depends on mbp_pkg.
module mbp_front import mbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            op_i,
  input  logic [VALUE_BITS-1:0] code_value_i,
  input  logic [LEN_W-1:0]      code_length_i,
  output logic                  pkt_valid_o,
  output packet_t               pkt_o
);

  logic [BYTE_BITS-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  op_e                             op;
  logic [LEN_W-1:0]                len;
  logic [LEN_W-1:0]                lsh;
  logic [VALUE_BITS-1:0]           v_lj;
  logic [VALUE_BITS+BYTE_BITS-1:0] win;
  logic [VALUE_BITS+BYTE_BITS-1:0] win_sh;
  logic [LEN_W-1:0]                total;
  logic [CNT_W-1:0]                nbytes;

  assign op  = op_e'(op_i);
  assign len = (code_length_i > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : code_length_i;
  assign lsh = LEN_W'(VALUE_BITS) - len;

  // Left-justify the code; bits above the length fall off the top.
  assign v_lj = (len == '0) ? '0 : (code_value_i << lsh[LEN_W-2:0]);

  // 40-bit window: pending bits first, then the code right behind them.
  assign win    = {bits_q, {VALUE_BITS{1'b0}}} | ({v_lj, {BYTE_BITS{1'b0}}} >> cnt_q);
  assign total  = len + LEN_W'(cnt_q);
  assign nbytes = total[LEN_W-1:CNT_W];
  assign win_sh = win << {nbytes, 3'b000};

  always_comb begin
    pkt_o  = '0;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    case (op)
      OP_WRITE: begin
        for (int k = 0; k < MAX_BYTES; k++) begin
          pkt_o.bytes[k] = win[VALUE_BITS+BYTE_BITS-1-BYTE_BITS*k -: BYTE_BITS];
        end
        pkt_o.cnt = nbytes;
        bits_d    = win_sh[VALUE_BITS+BYTE_BITS-1 -: BYTE_BITS];
        cnt_d     = total[CNT_W-1:0];
      end
      OP_ALIGN_ONES: begin
        pkt_o.bytes[0] = bits_q | (8'hFF >> cnt_q);
        pkt_o.cnt      = (cnt_q != '0) ? CNT_W'(1) : '0;
        bits_d         = '0;
        cnt_d          = '0;
      end
      OP_FLUSH_ZEROS: begin
        pkt_o.bytes[0] = bits_q;
        pkt_o.cnt      = (cnt_q != '0) ? CNT_W'(1) : '0;
        bits_d         = '0;
        cnt_d          = '0;
      end
      OP_TRAIL_ALIGN: begin
        // stop bit lands right after the pending bits, even with 7 pending
        pkt_o.bytes[0] = bits_q | (8'h80 >> cnt_q);
        pkt_o.cnt      = CNT_W'(1);
        bits_d         = '0;
        cnt_d          = '0;
      end
      default: begin
        pkt_o.cnt = '0;
      end
    endcase
  end

  assign pkt_valid_o = accept_i && (pkt_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/mbp_queue.sv =====
// Two-entry packet queue between front and back end.
// Depends on mbp_pkg.
module mbp_queue import mbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  packet_t wdata_i,
  input  logic    rd_i,
  output packet_t rdata_o,
  output logic    full_o,
  output logic    empty_o
);

  packet_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_rd) rptr_q <= rptr_q + QPTR_W'(1);
      count_q <= count_q + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

endmodule

// ===== rtl/core/mbp_back.sv =====
// Back end: unloads packets from the queue and hands out one byte per
// pop, flagging the last byte of each packet. Depends on mbp_pkg.
module mbp_back import mbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  packet_t              pkt_i,
  input  logic                 pkt_avail_i,
  output logic                 pkt_take_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [BYTE_BITS-1:0] out_byte_o,
  output logic                 last_byte_o
);

  packet_t          cur_q;
  logic             valid_q;
  logic [IDX_W-1:0] idx_q;
  logic             last;
  logic             take_byte;

  assign last        = ({1'b0, idx_q} == CNT_W'(cur_q.cnt - CNT_W'(1)));
  assign take_byte   = pop_i && valid_q;
  assign pkt_take_o  = pkt_avail_i && (!valid_q || (take_byte && last));
  assign empty_o     = !valid_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign last_byte_o = last;

  always_ff @(posedge clk_i) begin
    if (pkt_take_o) begin
      cur_q <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pkt_take_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take_byte) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // empty packets never reach the back end
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cur_q.cnt != '0))
    else $error("back end holds a packet with no bytes");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, idx_q} < cur_q.cnt))
    else $error("byte index beyond packet length");

  a_mid_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_byte && !last) |=> (valid_q && $stable(cur_q.cnt)))
    else $error("packet dropped before its last byte");

  a_last_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_byte && last && !pkt_avail_i) |=> !valid_q)
    else $error("stale packet after last byte");

endmodule

// ===== rtl/core/msb_first_bit_packer_core.sv =====
// MSB-first bit packer: appends codes of 0..32 bits to a byte stream.
// Accepts one word per cycle while full is low; a word yields 0..4 bytes,
// which leave in stream order one per pop, the last one of each word
// flagged. A word that yields n bytes (four at most for a full 32-bit
// write) takes n pops; words yielding no byte never enter the queue. The
// one-byte result port sets the sustained rate of one byte per cycle while
// pop is held and bytes are waiting. A word's packet is written to the
// two-entry packet queue, then loaded into the back end's packet register
// once that is free; the queue separates the input side from the result side. Depends on mbp_pkg and the mbp_* modules.
module msb_first_bit_packer_core import mbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            op_i,
  input  logic [VALUE_BITS-1:0] code_value_i,
  input  logic [LEN_W-1:0]      code_length_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [BYTE_BITS-1:0]  out_byte_o,
  output logic                  last_byte_o
);

  logic    accept;
  logic    pkt_valid;
  packet_t pkt_in, pkt_out;
  logic    q_empty;
  logic    pkt_take;

  assign accept = push && !full;

  mbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_i),
    .code_value_i  (code_value_i),
    .code_length_i (code_length_i),
    .pkt_valid_o   (pkt_valid),
    .pkt_o         (pkt_in)
  );

  mbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (pkt_valid),
    .wdata_i (pkt_in),
    .rd_i    (pkt_take),
    .rdata_o (pkt_out),
    .full_o  (full),
    .empty_o (q_empty)
  );

  mbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_out),
    .pkt_avail_i (!q_empty),
    .pkt_take_o  (pkt_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule
